/* hdl/i2c_eeprom_byte_transfer_master_assert.svh */
// Assertion macros shared by the master and sequencer RTL files.
// Define ASSERT_OFF to compile the checks out.
`ifndef I2C_EEPROM_BYTE_TRANSFER_MASTER_ASSERT_SVH
`define I2C_EEPROM_BYTE_TRANSFER_MASTER_ASSERT_SVH

`ifndef ASSERT_OFF

// cons holds in the same cycle as ante
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// cons holds in the cycle after ante
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(name, clk, rst, ante, cons)

`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

/* hdl/i2cee_pkg.sv */
package i2cee_pkg;

   localparam logic [9:0] MAX_BYTES = 10'd512;

   // request action codes
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_LOAD  = 2'd1;
   localparam logic [1:0] ACT_STORE = 2'd2;

   // transfer status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NACK     = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_FIRST_BLOCK  = 2'd0;
   localparam logic [1:0] CSR_SECOND_BLOCK = 2'd1;
   localparam logic [1:0] CSR_SHORT_TICKS  = 2'd2;
   localparam logic [1:0] CSR_LONG_TICKS   = 2'd3;

   localparam logic [7:0] CTRL_WRITE    = 8'hA0;
   localparam logic [7:0] CTRL_READ_BIT = 8'h01;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] start_address;
      logic [9:0] byte_count;
      logic [3:0] device_bits;
      logic [3:0] block_bits;
      logic [7:0] write_data;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       read_valid;
      logic [7:0] read_data;
      logic       byte_taken;
      logic       done_res;
      logic [1:0] status;
      logic [9:0] bytes_done;
   } rsp_type;

   typedef struct packed {
      logic [3:0] first_block_bits;
      logic [3:0] second_block_bits;
      logic [7:0] short_phase_ticks;
      logic [7:0] long_phase_ticks;
   } cfg_type;

   // bus primitive run by a phase
   typedef enum logic [2:0] {
      OP_START = 3'd0,
      OP_STOP  = 3'd1,
      OP_WBYTE = 3'd2,
      OP_RBYTE = 3'd3,
      OP_RACK  = 3'd4,
      OP_WACK  = 3'd5
   } op_type;

   typedef enum logic [21:0] {
      PH_IDLE       = 22'h000001,
      PH_L_START1   = 22'h000002,
      PH_L_CTRLW    = 22'h000004,
      PH_L_ACK1     = 22'h000008,
      PH_L_ADDR     = 22'h000010,
      PH_L_ACK2     = 22'h000020,
      PH_L_START2   = 22'h000040,
      PH_L_CTRLR    = 22'h000080,
      PH_L_ACK3     = 22'h000100,
      PH_L_READ     = 22'h000200,
      PH_L_NACK     = 22'h000400,
      PH_L_STOP     = 22'h000800,
      PH_S_START    = 22'h001000,
      PH_S_CTRLW    = 22'h002000,
      PH_S_ACK1     = 22'h004000,
      PH_S_POLLSTOP = 22'h008000,
      PH_S_ADDR     = 22'h010000,
      PH_S_ACK2     = 22'h020000,
      PH_S_DATA     = 22'h040000,
      PH_S_ACK3     = 22'h080000,
      PH_S_STOP     = 22'h100000,
      PH_ERR_STOP   = 22'h200000
   } phase_type;

   function automatic op_type phase_op(input phase_type ph);
      op_type op;
      case (ph)
         PH_L_START1, PH_L_START2, PH_S_START: op = OP_START;
         PH_L_CTRLW, PH_L_ADDR, PH_L_CTRLR,
         PH_S_CTRLW, PH_S_ADDR, PH_S_DATA: op = OP_WBYTE;
         PH_L_READ: op = OP_RBYTE;
         PH_L_ACK1, PH_L_ACK2, PH_L_ACK3,
         PH_S_ACK1, PH_S_ACK2, PH_S_ACK3: op = OP_RACK;
         PH_L_NACK: op = OP_WACK;
         default: op = OP_STOP;
      endcase
      return op;
   endfunction

endpackage

/* hdl/i2c_eeprom_byte_transfer_master.sv */
// Channel  Ports                                  Direction  Payload
// request  req_valid, req_ready, req_data         in         i2cee_pkg::req_type
// result   rsp_valid, rsp_ready, rsp_data         out        i2cee_pkg::rsp_type
// csr      csr_valid, csr_ready, csr_index/_data  in         2-bit index, 8-bit data
//
// One result per request. A request goes through the request register, then
// one pass through the bus sequencer into the result register. Throughput is
// one request per cycle while the result is not stalled, one sequencer step
// per request. Reset (synchronous, active high) returns the sequencer to
// idle and loads register defaults. A stalled result holds the request stage;
// the request stage takes a new request in the same cycle it moves on.
`include "i2c_eeprom_byte_transfer_master_assert.svh"

module i2c_eeprom_byte_transfer_master (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cee_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cee_pkg::rsp_type  rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_data
);
   import i2cee_pkg::*;

   // request stage
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;

   // result stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   logic    out_free;
   logic    step_en;
   cfg_type cfg;
   rsp_type step_result;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_en   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;

   assign s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !step_en);
   assign rsp_valid_in = step_en || (rsp_valid_ff && !rsp_ready);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   i2cee_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // bus sequencer: one tick per step
   i2cee_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (s1_data_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_data_ff <= req_data;
      end
      if (step_en) begin
         rsp_data_ff <= step_result;
      end
   end

   // a held request stays put until the sequencer takes it
   `ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !step_en, s1_valid_ff && $stable(s1_data_ff))
   // every step lands in the result register
   `ASSERT_NEXT(a_step_to_rsp, clock, reset, step_en, rsp_valid_ff)

endmodule

/* hdl/i2cee_csr.sv */
module i2cee_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [7:0]          csr_data,
   output i2cee_pkg::cfg_type  cfg
);
   import i2cee_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_FIRST_BLOCK:  cfg_in.first_block_bits  = csr_data[3:0];
            CSR_SECOND_BLOCK: cfg_in.second_block_bits = csr_data[3:0];
            CSR_SHORT_TICKS:  cfg_in.short_phase_ticks = csr_data;
            CSR_LONG_TICKS:   cfg_in.long_phase_ticks  = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_block_bits  <= 4'd0;
         cfg_ff.second_block_bits <= 4'd2;
         cfg_ff.short_phase_ticks <= 8'd2;
         cfg_ff.long_phase_ticks  <= 8'd3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hdl/i2cee_seq.sv */
`include "i2c_eeprom_byte_transfer_master_assert.svh"

module i2cee_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  i2cee_pkg::req_type  item,
   input  i2cee_pkg::cfg_type  cfg,
   output i2cee_pkg::rsp_type  result
);
   import i2cee_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] tick_ff, tick_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] addr_ff, addr_in;
   logic [3:0] block_ff, block_in;
   logic [3:0] device_ff, device_in;
   logic [9:0] remaining_ff, remaining_in;
   logic [9:0] completed_ff, completed_in;
   logic [1:0] segment_ff, segment_in;
   logic [1:0] end_code_ff, end_code_in;
   logic       nack_ff, nack_in;

   op_type     cur_op;
   op_type     held_op;
   logic       scl_lvl, sda_lvl, drv, is_long;
   logic [7:0] dur, tick_inc, ctrl;
   logic [1:0] seg_last;
   logic [9:0] start_cnt;
   logic       read_valid, byte_taken, done;
   logic [7:0] read_data;
   logic [1:0] status;

   assign start_cnt = (item.byte_count > MAX_BYTES) ? MAX_BYTES : item.byte_count;
   assign held_op   = phase_op(phase_ff);

   always_comb begin
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      bit_in       = bit_ff;
      shift_in     = shift_ff;
      addr_in      = addr_ff;
      block_in     = block_ff;
      device_in    = device_ff;
      remaining_in = remaining_ff;
      completed_in = completed_ff;
      segment_in   = segment_ff;
      end_code_in  = end_code_ff;
      nack_in      = nack_ff;
      cur_op       = OP_STOP;
      scl_lvl      = 1'b1;
      sda_lvl      = 1'b0;
      drv          = 1'b0;
      is_long      = 1'b0;
      dur          = 8'd1;
      tick_inc     = 8'd0;
      seg_last     = 2'd2;
      ctrl         = CTRL_WRITE;
      read_valid   = 1'b0;
      read_data    = 8'd0;
      byte_taken   = 1'b0;
      done         = 1'b0;
      status       = ST_OK;

      if (step_en) begin
         // transfer start
         if (phase_ff == PH_IDLE && (item.action == ACT_LOAD || item.action == ACT_STORE)) begin
            remaining_in = start_cnt;
            completed_in = 10'd0;
            addr_in      = item.start_address;
            device_in    = item.device_bits;
            block_in     = item.block_bits;
            end_code_in  = ST_OK;
            segment_in   = 2'd0;
            bit_in       = 3'd0;
            tick_in      = 8'd0;
            nack_in      = 1'b0;
            if (start_cnt == 10'd0) begin
               phase_in = PH_IDLE;
               done     = 1'b1;
               status   = ST_OK;
            end else if (item.action == ACT_STORE) begin
               phase_in = PH_S_START;
            end else begin
               phase_in = PH_L_START1;
            end
         end

         if (phase_in != PH_IDLE) begin
            cur_op = phase_op(phase_in);
            case (cur_op)
               OP_START: begin
                  scl_lvl = (segment_in < 2'd2);
                  sda_lvl = (segment_in == 2'd0);
                  drv     = 1'b1;
               end
               OP_STOP: begin
                  scl_lvl = (segment_in > 2'd0);
                  sda_lvl = (segment_in == 2'd2);
                  drv     = 1'b1;
               end
               OP_WBYTE: begin
                  scl_lvl = (segment_in == 2'd1);
                  sda_lvl = shift_in[7];
                  drv     = 1'b1;
                  is_long = (segment_in == 2'd1);
               end
               OP_RBYTE: begin
                  scl_lvl = (segment_in == 2'd1);
                  is_long = (segment_in == 2'd1);
               end
               OP_RACK: begin
                  scl_lvl  = (segment_in == 2'd1) || (segment_in == 2'd2);
                  seg_last = 2'd3;
               end
               default: begin
                  scl_lvl = (segment_in == 2'd1);
                  sda_lvl = 1'b1;
                  drv     = 1'b1;
                  is_long = (segment_in == 2'd1);
               end
            endcase

            dur = is_long ? cfg.long_phase_ticks : cfg.short_phase_ticks;
            if (dur == 8'd0) begin
               dur = 8'd1;
            end
            tick_inc = tick_in + 8'd1;

            if (tick_inc >= dur) begin
               tick_in = 8'd0;
               if (cur_op == OP_RBYTE && segment_in == 2'd1) begin
                  shift_in = {shift_in[6:0], item.sda_in};
               end
               if (cur_op == OP_RACK && segment_in == 2'd1) begin
                  nack_in = item.sda_in;
               end
               if (cur_op == OP_WBYTE && segment_in == 2'd2) begin
                  shift_in = {shift_in[6:0], 1'b0};
               end

               if (segment_in >= seg_last) begin
                  segment_in = 2'd0;
                  if ((cur_op == OP_WBYTE || cur_op == OP_RBYTE) && bit_in != 3'd7) begin
                     bit_in = bit_in + 3'd1;
                  end else begin
                     // phase complete: pick the next phase
                     ctrl = CTRL_WRITE | {4'd0, device_in | block_in};
                     case (phase_in)
                        PH_L_START1: begin
                           shift_in = ctrl;
                           phase_in = PH_L_CTRLW;
                        end
                        PH_L_CTRLW: phase_in = PH_L_ACK1;
                        PH_L_ACK1: begin
                           if (nack_in) begin
                              end_code_in = ST_NACK;
                              phase_in    = PH_ERR_STOP;
                           end else begin
                              shift_in = addr_in;
                              addr_in  = addr_in + 8'd1;
                              phase_in = PH_L_ADDR;
                           end
                        end
                        PH_L_ADDR: phase_in = PH_L_ACK2;
                        PH_L_ACK2: begin
                           if (nack_in) begin
                              end_code_in = ST_NACK;
                              phase_in    = PH_ERR_STOP;
                           end else begin
                              phase_in = PH_L_START2;
                           end
                        end
                        PH_L_START2: begin
                           shift_in = ctrl | CTRL_READ_BIT;
                           phase_in = PH_L_CTRLR;
                        end
                        PH_L_CTRLR: phase_in = PH_L_ACK3;
                        PH_L_ACK3: begin
                           if (nack_in) begin
                              end_code_in = ST_NACK;
                              phase_in    = PH_ERR_STOP;
                           end else begin
                              shift_in = 8'd0;
                              phase_in = PH_L_READ;
                           end
                        end
                        PH_L_READ: begin
                           read_valid = 1'b1;
                           read_data  = shift_in;
                           phase_in   = PH_L_NACK;
                        end
                        PH_L_NACK: phase_in = PH_L_STOP;
                        PH_L_STOP: begin
                           completed_in = completed_in + 10'd1;
                           if (remaining_in != 10'd0) begin
                              remaining_in = remaining_in - 10'd1;
                           end
                           if (remaining_in == 10'd0) begin
                              phase_in = PH_IDLE;
                              done     = 1'b1;
                              status   = ST_OK;
                           end else if (addr_in == 8'd0 &&
                                        block_in != cfg.first_block_bits) begin
                              phase_in = PH_IDLE;
                              done     = 1'b1;
                              status   = ST_OVERFLOW;
                           end else begin
                              if (addr_in == 8'd0) begin
                                 block_in = cfg.second_block_bits;
                              end
                              phase_in = PH_L_START1;
                           end
                        end
                        PH_S_START: begin
                           shift_in = ctrl;
                           phase_in = PH_S_CTRLW;
                        end
                        PH_S_CTRLW: phase_in = PH_S_ACK1;
                        PH_S_ACK1: begin
                           if (nack_in) begin
                              phase_in = PH_S_POLLSTOP;
                           end else begin
                              shift_in = addr_in;
                              addr_in  = addr_in + 8'd1;
                              phase_in = PH_S_ADDR;
                           end
                        end
                        PH_S_POLLSTOP: phase_in = PH_S_START;
                        PH_S_ADDR:     phase_in = PH_S_ACK2;
                        PH_S_ACK2: begin
                           if (nack_in) begin
                              end_code_in = ST_NACK;
                              phase_in    = PH_ERR_STOP;
                           end else if (addr_in == 8'd0 && remaining_in != 10'd1 &&
                                        block_in != cfg.first_block_bits) begin
                              end_code_in = ST_OVERFLOW;
                              phase_in    = PH_ERR_STOP;
                           end else begin
                              if (addr_in == 8'd0 && remaining_in != 10'd1) begin
                                 block_in = cfg.second_block_bits;
                              end
                              shift_in   = item.write_data;
                              byte_taken = 1'b1;
                              phase_in   = PH_S_DATA;
                           end
                        end
                        PH_S_DATA: phase_in = PH_S_ACK3;
                        PH_S_ACK3: begin
                           if (nack_in) begin
                              end_code_in = ST_NACK;
                              phase_in    = PH_ERR_STOP;
                           end else begin
                              phase_in = PH_S_STOP;
                           end
                        end
                        PH_S_STOP: begin
                           completed_in = completed_in + 10'd1;
                           if (remaining_in != 10'd0) begin
                              remaining_in = remaining_in - 10'd1;
                           end
                           if (remaining_in == 10'd0) begin
                              phase_in = PH_IDLE;
                              done     = 1'b1;
                              status   = ST_OK;
                           end else begin
                              phase_in = PH_S_START;
                           end
                        end
                        default: begin
                           // error stop finished
                           phase_in = PH_IDLE;
                           done     = 1'b1;
                           status   = end_code_in;
                        end
                     endcase
                     bit_in  = 3'd0;
                     nack_in = 1'b0;
                  end
               end else begin
                  segment_in = segment_in + 2'd1;
               end
            end else begin
               tick_in = tick_inc;
            end
         end
      end
   end

   always_comb begin
      result.scl        = scl_lvl;
      result.sda_out    = drv & sda_lvl;
      result.sda_drive  = drv;
      result.busy_res   = (phase_in != PH_IDLE);
      result.read_valid = read_valid;
      result.read_data  = read_data;
      result.byte_taken = byte_taken;
      result.done_res   = done;
      result.status     = status;
      result.bytes_done = completed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= 8'd0;
         bit_ff       <= 3'd0;
         shift_ff     <= 8'd0;
         addr_ff      <= 8'd0;
         block_ff     <= 4'd0;
         device_ff    <= 4'd0;
         remaining_ff <= 10'd0;
         completed_ff <= 10'd0;
         segment_ff   <= 2'd0;
         end_code_ff  <= 2'd0;
         nack_ff      <= 1'b0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         addr_ff      <= addr_in;
         block_ff     <= block_in;
         device_ff    <= device_in;
         remaining_ff <= remaining_in;
         completed_ff <= completed_in;
         segment_ff   <= segment_in;
         end_code_ff  <= end_code_in;
         nack_ff      <= nack_in;
      end
   end

   // sequencer only moves on a step
   `ASSERT_NEXT(a_hold_no_step, clock, reset, !step_en, $stable(phase_ff) && $stable(completed_ff))
   // bit counter runs only inside byte phases
   `ASSERT_IMPLY(a_bit_in_byte, clock, reset, bit_ff != 3'd0, held_op == OP_WBYTE || held_op == OP_RBYTE)
   // fourth segment exists only in acknowledge reads
   `ASSERT_IMPLY(a_seg_in_ack, clock, reset, segment_ff == 2'd3, held_op == OP_RACK)

endmodule
